FILE: hdl/ecr_pkg.sv
// ----------------------------------------------------------------------------
// Elevation color ramp package
// Shared constants, register indexes and types for the elevation color ramp.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ecr_pkg;

   // Default widths of the elevation samples and of the normalized fraction.
   localparam int ELEVATION_BITS_DEFAULT = 16;
   localparam int FRACTION_BITS_DEFAULT  = 16;

   // Packed anchor colors hold three 8-bit channels, red on top.
   localparam int CHANNEL_BITS = 8;
   localparam int NUM_CHANNELS = 3;
   localparam int COLOR_BITS   = CHANNEL_BITS * NUM_CHANNELS;

   // Reset value of the maximum elevation register.
   localparam int MAX_ELEVATION_RESET = 32767;

   // Quotient bits resolved by each divider stage.
   localparam int DIV_STEPS_PER_STAGE = 2;

   // Register indexes of the configuration port.
   localparam int CSR_INDEX_BITS = 3;
   typedef logic [CSR_INDEX_BITS-1:0] csr_index_type;

   localparam csr_index_type CSR_MIN_ELEVATION      = 3'd0;
   localparam csr_index_type CSR_MAX_ELEVATION      = 3'd1;
   localparam csr_index_type CSR_COLOR_LOWLAND      = 3'd2;
   localparam csr_index_type CSR_COLOR_LOW_PLATEAU  = 3'd3;
   localparam csr_index_type CSR_COLOR_HIGH_PLATEAU = 3'd4;
   localparam csr_index_type CSR_COLOR_PEAK         = 3'd5;

   typedef logic [COLOR_BITS-1:0]   color_type;
   typedef logic [CHANNEL_BITS-1:0] channel_type;

   // How the fraction of one sample is formed after the range check.
   typedef enum logic [1:0] {
      MODE_ZERO,
      MODE_ONE,
      MODE_DIV
   } frac_mode_type;

endpackage

FILE: hdl/ecr_normalize.sv
// ----------------------------------------------------------------------------
// Elevation normalize stage
// Forms the offset of a sample from the minimum and the span of the range,
// folds a reversed range and classifies the sample as below, above or inside.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ecr_normalize #(
   parameter int ELEVATION_BITS = ecr_pkg::ELEVATION_BITS_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             in_valid,
   output logic                             in_ready,
   input  logic signed [ELEVATION_BITS-1:0] elevation,
   input  logic signed [ELEVATION_BITS-1:0] min_elevation,
   input  logic signed [ELEVATION_BITS-1:0] max_elevation,
   output logic                             out_valid,
   input  logic                             out_ready,
   output ecr_pkg::frac_mode_type           out_mode,
   output logic [ELEVATION_BITS-1:0]        out_num,
   output logic [ELEVATION_BITS-1:0]        out_den
);
   import ecr_pkg::*;

   logic signed [ELEVATION_BITS:0] num_full;
   logic signed [ELEVATION_BITS:0] den_full;
   logic signed [ELEVATION_BITS:0] num_adj;
   logic signed [ELEVATION_BITS:0] den_adj;
   frac_mode_type                  mode_in;

   logic                      valid_ff;
   frac_mode_type             mode_ff;
   logic [ELEVATION_BITS-1:0] num_ff;
   logic [ELEVATION_BITS-1:0] den_ff;

   // The stage takes a new sample when it is empty or its content moves on.
   assign in_ready = !valid_ff || out_ready;

   // Offset and span, with both signs flipped when the range is reversed.
   always_comb begin
      num_full = {elevation[ELEVATION_BITS-1], elevation}
               - {min_elevation[ELEVATION_BITS-1], min_elevation};
      den_full = {max_elevation[ELEVATION_BITS-1], max_elevation}
               - {min_elevation[ELEVATION_BITS-1], min_elevation};
      if (den_full < 0) begin
         num_adj = -num_full;
         den_adj = -den_full;
      end else begin
         num_adj = num_full;
         den_adj = den_full;
      end
      if (den_adj == '0 || num_adj <= 0) begin
         mode_in = MODE_ZERO;
      end else if (num_adj >= den_adj) begin
         mode_in = MODE_ONE;
      end else begin
         mode_in = MODE_DIV;
      end
   end

   // Stage register.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_ready) begin
         mode_ff <= mode_in;
         num_ff  <= num_adj[ELEVATION_BITS-1:0];
         den_ff  <= den_adj[ELEVATION_BITS-1:0];
      end
   end

   assign out_valid = valid_ff;
   assign out_mode  = mode_ff;
   assign out_num   = num_ff;
   assign out_den   = den_ff;

endmodule

FILE: hdl/ecr_divider.sv
// ----------------------------------------------------------------------------
// Fraction divider
// Pipelined restoring divider that forms the fraction bits of offset / span,
// a fixed number of quotient bits per stage, and then applies the clamp.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ecr_divider #(
   parameter int ELEVATION_BITS = ecr_pkg::ELEVATION_BITS_DEFAULT,
   parameter int FRACTION_BITS  = ecr_pkg::FRACTION_BITS_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   output logic                       in_ready,
   input  ecr_pkg::frac_mode_type     in_mode,
   input  logic [ELEVATION_BITS-1:0]  in_num,
   input  logic [ELEVATION_BITS-1:0]  in_den,
   output logic                       out_valid,
   input  logic                       out_ready,
   output logic [FRACTION_BITS:0]     out_frac
);
   import ecr_pkg::*;

   localparam int NUM_STAGES =
      (FRACTION_BITS + DIV_STEPS_PER_STAGE - 1) / DIV_STEPS_PER_STAGE;
   localparam logic [FRACTION_BITS:0] FRAC_ONE = {1'b1, {FRACTION_BITS{1'b0}}};

   logic                      valid_ff [NUM_STAGES];
   frac_mode_type             mode_ff  [NUM_STAGES];
   logic [ELEVATION_BITS-1:0] rem_ff   [NUM_STAGES];
   logic [ELEVATION_BITS-1:0] den_ff   [NUM_STAGES];
   logic [FRACTION_BITS-1:0]  quo_ff   [NUM_STAGES];
   logic                      stage_en [NUM_STAGES];

   for (genvar s = 0; s < NUM_STAGES; s++) begin : g_stage
      logic                      prev_valid;
      frac_mode_type             prev_mode;
      logic [ELEVATION_BITS-1:0] prev_rem;
      logic [ELEVATION_BITS-1:0] prev_den;
      logic [FRACTION_BITS-1:0]  prev_quo;
      logic [ELEVATION_BITS-1:0] rem_in;
      logic [FRACTION_BITS-1:0]  quo_in;

      // The first stage starts from the offset with an empty quotient.
      if (s == 0) begin : g_first
         assign prev_valid = in_valid;
         assign prev_mode  = in_mode;
         assign prev_rem   = in_num;
         assign prev_den   = in_den;
         assign prev_quo   = '0;
      end else begin : g_next
         assign prev_valid = valid_ff[s-1];
         assign prev_mode  = mode_ff[s-1];
         assign prev_rem   = rem_ff[s-1];
         assign prev_den   = den_ff[s-1];
         assign prev_quo   = quo_ff[s-1];
      end

      // A stage loads when it is empty or the stage after it loads.
      if (s == NUM_STAGES - 1) begin : g_last_en
         assign stage_en[s] = !valid_ff[s] || out_ready;
      end else begin : g_mid_en
         assign stage_en[s] = !valid_ff[s] || stage_en[s+1];
      end

      // Shift-and-subtract steps of this stage; the remainder stays below the span.
      always_comb begin : step_calc
         logic [ELEVATION_BITS:0]   rem_dbl;
         logic [ELEVATION_BITS-1:0] rem_t;
         logic [FRACTION_BITS-1:0]  quo_t;
         rem_t   = prev_rem;
         quo_t   = prev_quo;
         rem_dbl = '0;
         for (int j = 0; j < DIV_STEPS_PER_STAGE; j++) begin
            if (s * DIV_STEPS_PER_STAGE + j < FRACTION_BITS) begin
               rem_dbl = {rem_t, 1'b0};
               if (rem_dbl >= {1'b0, prev_den}) begin
                  rem_dbl = rem_dbl - {1'b0, prev_den};
                  quo_t   = {quo_t[FRACTION_BITS-2:0], 1'b1};
               end else begin
                  quo_t   = {quo_t[FRACTION_BITS-2:0], 1'b0};
               end
               rem_t = rem_dbl[ELEVATION_BITS-1:0];
            end
         end
         rem_in = rem_t;
         quo_in = quo_t;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else if (stage_en[s]) begin
            valid_ff[s] <= prev_valid;
         end
         if (stage_en[s]) begin
            mode_ff[s] <= prev_mode;
            rem_ff[s]  <= rem_in;
            den_ff[s]  <= prev_den;
            quo_ff[s]  <= quo_in;
         end
      end
   end

   assign in_ready  = stage_en[0];
   assign out_valid = valid_ff[NUM_STAGES-1];

   // Clamped fraction: zero at or below the range bottom or for an empty span, one at or above its top.
   always_comb begin
      case (mode_ff[NUM_STAGES-1])
         MODE_ZERO: out_frac = '0;
         MODE_ONE:  out_frac = FRAC_ONE;
         MODE_DIV:  out_frac = {1'b0, quo_ff[NUM_STAGES-1]};
         default:   out_frac = '0;
      endcase
   end

endmodule

FILE: hdl/ecr_blend.sv
// ----------------------------------------------------------------------------
// Color blend pipeline
// Picks the ramp segment of a fraction and interpolates the three channels
// between its anchor colors, rounding to nearest and saturating to 0..255.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ecr_blend #(
   parameter int FRACTION_BITS = ecr_pkg::FRACTION_BITS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  logic [FRACTION_BITS:0] in_frac,
   input  ecr_pkg::color_type   color_lowland,
   input  ecr_pkg::color_type   color_low_plateau,
   input  ecr_pkg::color_type   color_high_plateau,
   input  ecr_pkg::color_type   color_peak,
   output logic                 out_valid,
   input  logic                 out_ready,
   output ecr_pkg::channel_type out_red,
   output ecr_pkg::channel_type out_green,
   output ecr_pkg::channel_type out_blue
);
   import ecr_pkg::*;

   typedef enum logic [1:0] {
      SEG_LOW,
      SEG_MID,
      SEG_HIGH
   } seg_type;

   // Segment bounds and widths in fraction units.
   localparam int FRAC_ONE = 1 << FRACTION_BITS;
   localparam int T1       = (3 * FRAC_ONE + 5) / 10;
   localparam int T2       = (82 * FRAC_ONE + 50) / 100;
   localparam int W_LOW    = T1;
   localparam int W_MID    = T2 - T1;
   localparam int W_HIGH   = FRAC_ONE - T2;

   // The rounded quotient is biased by Q_OFFSET so that the dividend stays positive.
   localparam int Q_OFFSET = 1 << CHANNEL_BITS;
   localparam int QB       = CHANNEL_BITS + 1;
   localparam int DB       = FRACTION_BITS + 1;
   localparam int NB       = FRACTION_BITS + CHANNEL_BITS + 2;
   localparam int SHIFT    = NB;
   localparam int PW       = FRACTION_BITS + CHANNEL_BITS + 2;
   localparam int PB       = PW + 1;
   localparam int VB       = CHANNEL_BITS + 3;

   // Divisors (twice the width), rounding bias constants and reciprocals.
   localparam longint D_LOW  = 2 * W_LOW;
   localparam longint D_MID  = 2 * W_MID;
   localparam longint D_HIGH = 2 * W_HIGH;
   localparam longint C_LOW  = longint'(2 * Q_OFFSET + 1) * W_LOW;
   localparam longint C_MID  = longint'(2 * Q_OFFSET + 1) * W_MID;
   localparam longint C_HIGH = longint'(2 * Q_OFFSET + 1) * W_HIGH;
   localparam longint R_LOW  = (longint'(1) << SHIFT) / D_LOW;
   localparam longint R_MID  = (longint'(1) << SHIFT) / D_MID;
   localparam longint R_HIGH = (longint'(1) << SHIFT) / D_HIGH;
   localparam longint R_MAX01 = (R_LOW > R_MID) ? R_LOW : R_MID;
   localparam longint R_MAX  = (R_MAX01 > R_HIGH) ? R_MAX01 : R_HIGH;
   localparam int     RB     = $clog2(R_MAX + 1);

   localparam logic [FRACTION_BITS:0] T1_FRAC = (FRACTION_BITS + 1)'(T1);
   localparam logic [FRACTION_BITS:0] T2_FRAC = (FRACTION_BITS + 1)'(T2);
   localparam logic signed [VB-1:0] CHAN_MAX  = VB'((1 << CHANNEL_BITS) - 1);
   localparam logic signed [VB-1:0] CHAN_BIAS = VB'(Q_OFFSET);

   // Stage enables, last to first.
   logic en0, en1, en2, en3, en4;

   // Stage 0: segment, offset, low anchor and channel difference.
   logic                        v0_ff;
   seg_type                     seg0_ff;
   logic [FRACTION_BITS-1:0]    off0_ff;
   channel_type                 a0_ff [NUM_CHANNELS];
   logic signed [CHANNEL_BITS:0] d0_ff [NUM_CHANNELS];

   // Stage 1: biased dividend.
   logic                        v1_ff;
   seg_type                     seg1_ff;
   channel_type                 a1_ff [NUM_CHANNELS];
   logic [NB-1:0]               n1_ff [NUM_CHANNELS];

   // Stage 2: quotient estimate from the reciprocal.
   logic                        v2_ff;
   seg_type                     seg2_ff;
   channel_type                 a2_ff [NUM_CHANNELS];
   logic [NB-1:0]               n2_ff [NUM_CHANNELS];
   logic [QB-1:0]               qe2_ff [NUM_CHANNELS];

   // Stage 3: corrected quotient.
   logic                        v3_ff;
   channel_type                 a3_ff [NUM_CHANNELS];
   logic [QB-1:0]               q3_ff [NUM_CHANNELS];

   // Stage 4: output register.
   logic                        v4_ff;
   channel_type                 chan4_ff [NUM_CHANNELS];

   assign en4      = !v4_ff || out_ready;
   assign en3      = !v3_ff || en4;
   assign en2      = !v2_ff || en3;
   assign en1      = !v1_ff || en2;
   assign en0      = !v0_ff || en1;
   assign in_ready = en0;

   // ---- Stage 0 ----
   seg_type                      seg_in;
   logic [FRACTION_BITS:0]       off_full;
   color_type                    lo_color;
   color_type                    hi_color;
   channel_type                  a_in [NUM_CHANNELS];
   logic signed [CHANNEL_BITS:0] d_in [NUM_CHANNELS];

   // Segment choice; each segment blends between two neighboring anchors.
   always_comb begin
      if (in_frac >= T2_FRAC) begin
         seg_in = SEG_HIGH;
      end else if (in_frac >= T1_FRAC) begin
         seg_in = SEG_MID;
      end else begin
         seg_in = SEG_LOW;
      end
      case (seg_in)
         SEG_LOW: begin
            off_full = in_frac;
            lo_color = color_lowland;
            hi_color = color_low_plateau;
         end
         SEG_MID: begin
            off_full = in_frac - T1_FRAC;
            lo_color = color_low_plateau;
            hi_color = color_high_plateau;
         end
         SEG_HIGH: begin
            off_full = in_frac - T2_FRAC;
            lo_color = color_high_plateau;
            hi_color = color_peak;
         end
         default: begin
            off_full = in_frac;
            lo_color = color_lowland;
            hi_color = color_low_plateau;
         end
      endcase
      for (int k = 0; k < NUM_CHANNELS; k++) begin
         a_in[k] = lo_color[(NUM_CHANNELS - 1 - k) * CHANNEL_BITS +: CHANNEL_BITS];
         d_in[k] = $signed({1'b0, hi_color[(NUM_CHANNELS - 1 - k) * CHANNEL_BITS +:
                                           CHANNEL_BITS]})
                 - $signed({1'b0, a_in[k]});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
      end else if (en0) begin
         v0_ff <= in_valid;
      end
      if (en0) begin
         seg0_ff <= seg_in;
         off0_ff <= off_full[FRACTION_BITS-1:0];
         for (int k = 0; k < NUM_CHANNELS; k++) begin
            a0_ff[k] <= a_in[k];
            d0_ff[k] <= d_in[k];
         end
      end
   end

   // ---- Stage 1 ----
   logic signed [PW-1:0] prod1 [NUM_CHANNELS];
   logic [PB-1:0]        sum1  [NUM_CHANNELS];
   logic [PB-1:0]        c_sel;

   // Dividend 2*diff*offset + width + 2*width*Q_OFFSET, always positive.
   always_comb begin
      case (seg0_ff)
         SEG_LOW:  c_sel = PB'(C_LOW);
         SEG_MID:  c_sel = PB'(C_MID);
         SEG_HIGH: c_sel = PB'(C_HIGH);
         default:  c_sel = PB'(C_LOW);
      endcase
      for (int k = 0; k < NUM_CHANNELS; k++) begin
         prod1[k] = PW'(d0_ff[k]) * PW'($signed({1'b0, off0_ff}));
         sum1[k]  = {prod1[k], 1'b0} + c_sel;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (en1) begin
         v1_ff <= v0_ff;
      end
      if (en1) begin
         seg1_ff <= seg0_ff;
         for (int k = 0; k < NUM_CHANNELS; k++) begin
            a1_ff[k] <= a0_ff[k];
            n1_ff[k] <= sum1[k][NB-1:0];
         end
      end
   end

   // ---- Stage 2 ----
   logic [RB-1:0]    r_sel;
   logic [NB+RB-1:0] prod2 [NUM_CHANNELS];

   // Estimate is the true quotient or one below it.
   always_comb begin
      case (seg1_ff)
         SEG_LOW:  r_sel = RB'(R_LOW);
         SEG_MID:  r_sel = RB'(R_MID);
         SEG_HIGH: r_sel = RB'(R_HIGH);
         default:  r_sel = RB'(R_LOW);
      endcase
      for (int k = 0; k < NUM_CHANNELS; k++) begin
         prod2[k] = (NB + RB)'(n1_ff[k]) * (NB + RB)'(r_sel);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (en2) begin
         v2_ff <= v1_ff;
      end
      if (en2) begin
         seg2_ff <= seg1_ff;
         for (int k = 0; k < NUM_CHANNELS; k++) begin
            a2_ff[k]  <= a1_ff[k];
            n2_ff[k]  <= n1_ff[k];
            qe2_ff[k] <= prod2[k][SHIFT +: QB];
         end
      end
   end

   // ---- Stage 3 ----
   logic [DB-1:0] d_sel;
   logic [NB-1:0] back3 [NUM_CHANNELS];
   logic [NB-1:0] rem3  [NUM_CHANNELS];
   logic [QB-1:0] q_in  [NUM_CHANNELS];

   // Bump the estimate when the remainder still holds a whole divisor.
   always_comb begin
      case (seg2_ff)
         SEG_LOW:  d_sel = DB'(D_LOW);
         SEG_MID:  d_sel = DB'(D_MID);
         SEG_HIGH: d_sel = DB'(D_HIGH);
         default:  d_sel = DB'(D_LOW);
      endcase
      for (int k = 0; k < NUM_CHANNELS; k++) begin
         back3[k] = NB'(qe2_ff[k]) * NB'(d_sel);
         rem3[k]  = n2_ff[k] - back3[k];
         if (rem3[k] >= NB'(d_sel)) begin
            q_in[k] = qe2_ff[k] + QB'(1);
         end else begin
            q_in[k] = qe2_ff[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (en3) begin
         v3_ff <= v2_ff;
      end
      if (en3) begin
         for (int k = 0; k < NUM_CHANNELS; k++) begin
            a3_ff[k] <= a2_ff[k];
            q3_ff[k] <= q_in[k];
         end
      end
   end

   // ---- Stage 4 ----
   logic signed [VB-1:0] sum4 [NUM_CHANNELS];
   channel_type          chan_in [NUM_CHANNELS];

   // Remove the bias, add the low anchor and saturate each channel.
   always_comb begin
      for (int k = 0; k < NUM_CHANNELS; k++) begin
         sum4[k] = $signed({{(VB - CHANNEL_BITS){1'b0}}, a3_ff[k]})
                 + $signed({{(VB - QB){1'b0}}, q3_ff[k]})
                 - CHAN_BIAS;
         if (sum4[k] < 0) begin
            chan_in[k] = '0;
         end else if (sum4[k] > CHAN_MAX) begin
            chan_in[k] = '1;
         end else begin
            chan_in[k] = sum4[k][CHANNEL_BITS-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else if (en4) begin
         v4_ff <= v3_ff;
      end
      if (en4) begin
         for (int k = 0; k < NUM_CHANNELS; k++) begin
            chan4_ff[k] <= chan_in[k];
         end
      end
   end

   assign out_valid = v4_ff;
   assign out_red   = chan4_ff[0];
   assign out_green = chan4_ff[1];
   assign out_blue  = chan4_ff[2];

endmodule

FILE: hdl/elevation_color_ramp_top.sv
// ----------------------------------------------------------------------------
// Elevation color ramp
// Throughput: one sample per cycle while the response side does not stall; the
// divider resolves two quotient bits in each of its stages and every stage is registered.
// Reset clears all stage valid bits and loads the register reset values.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module elevation_color_ramp_top #(
   parameter int ELEVATION_BITS = ecr_pkg::ELEVATION_BITS_DEFAULT,
   parameter int FRACTION_BITS  = ecr_pkg::FRACTION_BITS_DEFAULT,
   parameter int CSR_DATA_BITS  = (ELEVATION_BITS > ecr_pkg::COLOR_BITS) ?
                                  ELEVATION_BITS : ecr_pkg::COLOR_BITS
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic signed [ELEVATION_BITS-1:0] req_elevation,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output ecr_pkg::channel_type             rsp_red,
   output ecr_pkg::channel_type             rsp_green,
   output ecr_pkg::channel_type             rsp_blue,
   input  logic                             csr_wr_en,
   input  ecr_pkg::csr_index_type           csr_index,
   input  logic [CSR_DATA_BITS-1:0]         csr_wr_data
);
   import ecr_pkg::*;

   localparam logic [FRACTION_BITS:0] FRAC_ONE = {1'b1, {FRACTION_BITS{1'b0}}};

   logic signed [ELEVATION_BITS-1:0] min_elev_ff;
   logic signed [ELEVATION_BITS-1:0] max_elev_ff;
   color_type                        color_lowland_ff;
   color_type                        color_low_plateau_ff;
   color_type                        color_high_plateau_ff;
   color_type                        color_peak_ff;

   logic                      norm_valid;
   logic                      norm_ready;
   frac_mode_type             norm_mode;
   logic [ELEVATION_BITS-1:0] norm_num;
   logic [ELEVATION_BITS-1:0] norm_den;

   logic                      div_valid;
   logic                      div_ready;
   logic [FRACTION_BITS:0]    div_frac;

   // Configuration registers; writes to unused indexes are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         min_elev_ff           <= '0;
         max_elev_ff           <= ELEVATION_BITS'(MAX_ELEVATION_RESET);
         color_lowland_ff      <= '0;
         color_low_plateau_ff  <= '0;
         color_high_plateau_ff <= '0;
         color_peak_ff         <= '0;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_MIN_ELEVATION:      min_elev_ff <= csr_wr_data[ELEVATION_BITS-1:0];
            CSR_MAX_ELEVATION:      max_elev_ff <= csr_wr_data[ELEVATION_BITS-1:0];
            CSR_COLOR_LOWLAND:      color_lowland_ff <= csr_wr_data[COLOR_BITS-1:0];
            CSR_COLOR_LOW_PLATEAU:  color_low_plateau_ff <= csr_wr_data[COLOR_BITS-1:0];
            CSR_COLOR_HIGH_PLATEAU: color_high_plateau_ff <= csr_wr_data[COLOR_BITS-1:0];
            CSR_COLOR_PEAK:         color_peak_ff <= csr_wr_data[COLOR_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   // Range check and offset of each sample.
   ecr_normalize #(
      .ELEVATION_BITS(ELEVATION_BITS)
   ) u_normalize (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (req_valid),
      .in_ready      (req_ready),
      .elevation     (req_elevation),
      .min_elevation (min_elev_ff),
      .max_elevation (max_elev_ff),
      .out_valid     (norm_valid),
      .out_ready     (norm_ready),
      .out_mode      (norm_mode),
      .out_num       (norm_num),
      .out_den       (norm_den)
   );

   // Fraction bits of offset over span.
   ecr_divider #(
      .ELEVATION_BITS(ELEVATION_BITS),
      .FRACTION_BITS (FRACTION_BITS)
   ) u_divider (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (norm_valid),
      .in_ready  (norm_ready),
      .in_mode   (norm_mode),
      .in_num    (norm_num),
      .in_den    (norm_den),
      .out_valid (div_valid),
      .out_ready (div_ready),
      .out_frac  (div_frac)
   );

   // Segment choice and channel interpolation.
   ecr_blend #(
      .FRACTION_BITS(FRACTION_BITS)
   ) u_blend (
      .clock              (clock),
      .reset              (reset),
      .in_valid           (div_valid),
      .in_ready           (div_ready),
      .in_frac            (div_frac),
      .color_lowland      (color_lowland_ff),
      .color_low_plateau  (color_low_plateau_ff),
      .color_high_plateau (color_high_plateau_ff),
      .color_peak         (color_peak_ff),
      .out_valid          (rsp_valid),
      .out_ready          (rsp_ready),
      .out_red            (rsp_red),
      .out_green          (rsp_green),
      .out_blue           (rsp_blue)
   );

`ifndef ASSERT_OFF
   // A sample sent to the divider lies strictly inside the range.
   assert property (@(posedge clock) disable iff (reset)
      norm_valid && norm_mode == MODE_DIV |-> norm_num < norm_den)
      else $error("divider operands out of order");

   // The clamped fraction never exceeds one.
   assert property (@(posedge clock) disable iff (reset)
      div_valid |-> div_frac <= FRAC_ONE)
      else $error("fraction above one");

   // No pixel transfer is offered right after reset.
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");
`endif

endmodule

FILE: test/tb_elevation_color_ramp_top.sv
// ----------------------------------------------------------------------------
// Elevation color ramp testbench
// Streams signed elevation samples through the color ramp under random
// source and sink idling. A local predictor normalizes each sample, picks
// the ramp segment and blends the anchor colors. Each pixel is checked
// channel by channel against the oldest prediction. Register settings
// change between phases, and the extremes are among them.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_elevation_color_ramp_top;

   import ecr_pkg::*;

   localparam int ELEV_BITS    = ELEVATION_BITS_DEFAULT;
   localparam int FRAC_BITS    = FRACTION_BITS_DEFAULT;
   localparam int LATENCY      = 6 + (FRAC_BITS + 1) / 2;
   localparam int DRAIN_CYCLES = LATENCY + 6;
   localparam int MAX_IDLE     = 12;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int RANDOM_PHASES    = 16;
   localparam int ITEMS_PER_PHASE  = 110;

   // Fraction scale and the two segment boundaries, 0.3 and 0.82 of one.
   localparam longint FRAC_ONE  = longint'(1) << FRAC_BITS;
   localparam longint SPLIT_LOW  = (3 * FRAC_ONE + 5) / 10;
   localparam longint SPLIT_HIGH = (82 * FRAC_ONE + 50) / 100;

   // Indexes past the last register; writes to them must change nothing.
   localparam csr_index_type CSR_SPARE_LOW  = 3'd6;
   localparam csr_index_type CSR_SPARE_HIGH = 3'd7;

   typedef struct packed {
      channel_type red;
      channel_type green;
      channel_type blue;
   } pixel_type;

   logic                        clock;
   logic                        reset         = 1'b1;
   logic                        req_valid     = 1'b0;
   logic                        req_ready;
   logic signed [ELEV_BITS-1:0] req_elevation = '0;
   logic                        rsp_valid;
   logic                        rsp_ready     = 1'b0;
   channel_type                 rsp_red;
   channel_type                 rsp_green;
   channel_type                 rsp_blue;
   logic                        csr_wr_en     = 1'b0;
   csr_index_type               csr_index     = CSR_MIN_ELEVATION;
   logic [COLOR_BITS-1:0]       csr_wr_data   = '0;

   // Local copy of the register file, starting at the reset values.
   logic signed [ELEV_BITS-1:0] ramp_min    = '0;
   logic signed [ELEV_BITS-1:0] ramp_max    = ELEV_BITS'(MAX_ELEVATION_RESET);
   color_type                   anchors [4] = '{default: '0};

   pixel_type expected_pixels [$];
   int        error_count = 0;
   int        cycle_count = 0;
   bit        steady_flow = 1'b0;

   elevation_color_ramp_top i_dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_elevation(req_elevation),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_red      (rsp_red),
      .rsp_green    (rsp_green),
      .rsp_blue     (rsp_blue),
      .csr_wr_en    (csr_wr_en),
      .csr_index    (csr_index),
      .csr_wr_data  (csr_wr_data)
   );

   // Clock generation.
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Run limit.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: run limit reached", $time);
         $display("DONE: errors detected");
         $finish;
      end
   end

   // Linear blend of one channel with round-to-nearest, ties upward.
   function automatic channel_type blend_channel(channel_type lo_c, channel_type hi_c,
                                                 longint offset, longint width);
      longint num;
      longint den;
      longint quo;
      num = 2 * (longint'(hi_c) - longint'(lo_c)) * offset + width;
      den = 2 * width;
      quo = num / den;
      if (num < 0 && quo * den != num) begin
         quo = quo - 1;
      end
      quo = longint'(lo_c) + quo;
      if (quo < 0) begin
         quo = 0;
      end
      if (quo > 255) begin
         quo = 255;
      end
      return channel_type'(quo[7:0]);
   endfunction

   // Color of one elevation sample under the current register settings.
   function automatic pixel_type ramp_pixel(logic signed [ELEV_BITS-1:0] elevation);
      longint    num;
      longint    den;
      longint    frac;
      longint    base;
      longint    width;
      color_type lo_col;
      color_type hi_col;
      pixel_type pix;
      num = longint'(elevation) - longint'(ramp_min);
      den = longint'(ramp_max) - longint'(ramp_min);
      if (den == 0) begin
         frac = 0;
      end else begin
         // A reversed range flips both signs before the clamp.
         if (den < 0) begin
            num = -num;
            den = -den;
         end
         if (num <= 0) begin
            frac = 0;
         end else if (num >= den) begin
            frac = FRAC_ONE;
         end else begin
            frac = (num * FRAC_ONE) / den;
         end
      end
      if (frac >= SPLIT_HIGH) begin
         lo_col = anchors[2];
         hi_col = anchors[3];
         base   = SPLIT_HIGH;
         width  = FRAC_ONE - SPLIT_HIGH;
      end else if (frac >= SPLIT_LOW) begin
         lo_col = anchors[1];
         hi_col = anchors[2];
         base   = SPLIT_LOW;
         width  = SPLIT_HIGH - SPLIT_LOW;
      end else begin
         lo_col = anchors[0];
         hi_col = anchors[1];
         base   = 0;
         width  = SPLIT_LOW;
      end
      pix.red   = blend_channel(lo_col[23:16], hi_col[23:16], frac - base, width);
      pix.green = blend_channel(lo_col[15:8], hi_col[15:8], frac - base, width);
      pix.blue  = blend_channel(lo_col[7:0], hi_col[7:0], frac - base, width);
      return pix;
   endfunction

   // Every accepted sample queues its predicted pixel.
   always @(posedge clock) begin
      if (!reset && req_valid && req_ready) begin
         expected_pixels.push_back(ramp_pixel(req_elevation));
      end
   end

   task automatic report_channel(string name, channel_type want, channel_type got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         error_count++;
      end
   endtask

   // Each pixel transfer is compared with the oldest prediction.
   always @(posedge clock) begin
      pixel_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_pixels.size() == 0) begin
            $display("%0t: unexpected pixel, expected none, actual %0d/%0d/%0d",
                     $time, rsp_red, rsp_green, rsp_blue);
            error_count++;
         end else begin
            want = expected_pixels.pop_front();
            report_channel("red", want.red, rsp_red);
            report_channel("green", want.green, rsp_green);
            report_channel("blue", want.blue, rsp_blue);
         end
      end
   end

   // The pixel sink stalls a random number of cycles before each transfer.
   initial begin
      int stall;
      forever begin
         stall = steady_flow ? 0 : $urandom_range(0, MAX_IDLE);
         if (stall > 0) begin
            @(negedge clock);
            rsp_ready <= 1'b0;
            repeat (stall - 1) @(negedge clock);
         end
         @(negedge clock);
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
      end
   end

   // Sends one sample after a random gap and waits for its transfer.
   task automatic send_elevation(input logic signed [ELEV_BITS-1:0] elevation);
      int gap;
      gap = steady_flow ? 0 : $urandom_range(0, MAX_IDLE);
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid     <= 1'b1;
      req_elevation <= elevation;
      do @(posedge clock); while (!(req_valid && req_ready));
   endtask

   // Stops sending and waits until the pipeline has emptied.
   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_pixels.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // One register write; the local copy follows the same masking rules.
   task automatic write_register(input csr_index_type index,
                                 input logic [COLOR_BITS-1:0] data);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_index   <= index;
      csr_wr_data <= data;
      @(posedge clock);
      case (index)
         CSR_MIN_ELEVATION:      ramp_min   = data[ELEV_BITS-1:0];
         CSR_MAX_ELEVATION:      ramp_max   = data[ELEV_BITS-1:0];
         CSR_COLOR_LOWLAND:      anchors[0] = data;
         CSR_COLOR_LOW_PLATEAU:  anchors[1] = data;
         CSR_COLOR_HIGH_PLATEAU: anchors[2] = data;
         CSR_COLOR_PEAK:         anchors[3] = data;
         default: ;
      endcase
   endtask

   task automatic end_writes();
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // Loads a full set of registers once the block is idle.
   task automatic configure_ramp(input int lo_elev, input int hi_elev,
                                 input color_type c0, input color_type c1,
                                 input color_type c2, input color_type c3);
      settle();
      write_register(CSR_MIN_ELEVATION, COLOR_BITS'(lo_elev[ELEV_BITS-1:0]));
      write_register(CSR_MAX_ELEVATION, COLOR_BITS'(hi_elev[ELEV_BITS-1:0]));
      write_register(CSR_COLOR_LOWLAND, c0);
      write_register(CSR_COLOR_LOW_PLATEAU, c1);
      write_register(CSR_COLOR_HIGH_PLATEAU, c2);
      write_register(CSR_COLOR_PEAK, c3);
      end_writes();
   endtask

   // The elevation range keeps its reset values; only the colors change.
   task automatic test_reset_range();
      write_register(CSR_COLOR_LOWLAND, 24'h102030);
      write_register(CSR_COLOR_LOW_PLATEAU, 24'hF0E0D0);
      write_register(CSR_COLOR_HIGH_PLATEAU, 24'h00FF00);
      write_register(CSR_COLOR_PEAK, 24'hFF00FF);
      end_writes();
      send_elevation(-16'sd32768);
      send_elevation(16'sd0);
      send_elevation(16'sd16384);
      send_elevation(16'sd32767);
   endtask

   // Field extremes, range ends and both sides of each segment boundary.
   task automatic test_segment_edges();
      configure_ramp(-1000, 1000, 24'h000000, 24'hFFFFFF, 24'h00FF80, 24'hFF0001);
      send_elevation(-16'sd32768);
      send_elevation(16'sd32767);
      send_elevation(-16'sd1000);
      send_elevation(16'sd1000);
      send_elevation(-16'sd400);
      send_elevation(-16'sd399);
      send_elevation(16'sd640);
      send_elevation(16'sd641);
      send_elevation(16'sd0);
      send_elevation(-16'sd999);
   endtask

   // Equal, reversed and full elevation ranges.
   task automatic test_range_shapes();
      configure_ramp(500, 500, 24'h123456, 24'hABCDEF, 24'h777777, 24'hFEDCBA);
      send_elevation(16'sd499);
      send_elevation(16'sd500);
      send_elevation(16'sd501);
      configure_ramp(1000, -1000, 24'h00FF00, 24'hFF0000, 24'h0000FF, 24'hFFFFFF);
      send_elevation(16'sd1000);
      send_elevation(16'sd0);
      send_elevation(-16'sd1000);
      send_elevation(-16'sd32768);
      configure_ramp(-32768, 32767, 24'hFFFFFF, 24'h000000, 24'hFFFFFF, 24'h000000);
      send_elevation(-16'sd32768);
      send_elevation(16'sd32767);
   endtask

   // Writes to spare indexes are dropped, as are data bits above a register.
   task automatic test_ignored_writes();
      settle();
      write_register(CSR_SPARE_LOW, 24'hFFFFFF);
      write_register(CSR_SPARE_HIGH, 24'h000000);
      write_register(CSR_MIN_ELEVATION, 24'hA58000);
      write_register(CSR_MAX_ELEVATION, 24'h5A7FFF);
      end_writes();
      send_elevation(16'sd0);
      send_elevation(16'sd20000);
   endtask

   // Random settings per phase with mostly in-range samples.
   task automatic test_random_ramps();
      int        lo_e;
      int        hi_e;
      int        span;
      int        mode;
      int        low_end;
      int        high_end;
      color_type cols [4];
      logic [ELEV_BITS-1:0] raw;
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         // The first phases go through every range shape in turn.
         mode = (phase < 5) ? phase : $urandom_range(0, 5);
         lo_e = int'($urandom_range(0, 65535)) - 32768;
         hi_e = int'($urandom_range(0, 65535)) - 32768;
         case (mode)
            0: begin
               lo_e = -32768;
               hi_e = 32767;
            end
            1: hi_e = lo_e;
            2: ;
            3: begin
               span = $urandom_range(1, 40);
               hi_e = lo_e + span;
               if (hi_e > 32767) begin
                  hi_e = 32767;
                  lo_e = hi_e - span;
               end
            end
            default: begin
               if (lo_e > hi_e) begin
                  span = lo_e;
                  lo_e = hi_e;
                  hi_e = span;
               end
            end
         endcase
         for (int k = 0; k < 4; k++) begin
            case ($urandom_range(0, 3))
               0:       cols[k] = '0;
               1:       cols[k] = '1;
               default: cols[k] = color_type'($urandom_range(0, 24'hFFFFFF));
            endcase
         end
         configure_ramp(lo_e, hi_e, cols[0], cols[1], cols[2], cols[3]);
         steady_flow = (phase == 6) || (phase == 11);
         low_end  = (lo_e < hi_e) ? lo_e : hi_e;
         high_end = (lo_e < hi_e) ? hi_e : lo_e;
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            case ($urandom_range(0, 9))
               7:       raw = low_end[ELEV_BITS-1:0];
               8:       raw = high_end[ELEV_BITS-1:0];
               9:       raw = ELEV_BITS'($urandom_range(0, 65535));
               default: begin
                  span = low_end + int'($urandom_range(0, high_end - low_end));
                  raw  = span[ELEV_BITS-1:0];
               end
            endcase
            send_elevation(raw);
         end
         steady_flow = 1'b0;
      end
   endtask

   // Test sequence.
   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_reset_range();
      test_segment_edges();
      test_range_shapes();
      test_ignored_writes();
      test_random_ramps();
      settle();
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
